// ----- src/multi_timer_expiry_unit_assert.svh -----
// Assertion macros shared by the timer unit RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTI_TIMER_EXPIRY_UNIT_ASSERT_SVH
`define MULTI_TIMER_EXPIRY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTEU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTEU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mteu_pkg.sv -----
// Package for the multi-timer expiry unit: opcodes, result kinds, FSM states,
// field widths and the control struct for the expiry ordering block. No dependencies.
`timescale 1ns / 1ps

package mteu_pkg;

    localparam int OP_W      = 3;
    localparam int IDX_W     = 3;
    localparam int IDX_SPAN  = 8;   // timers reachable through the 3-bit index
    localparam int PER_W     = 31;
    localparam int MASK_W    = 8;

    localparam logic [PER_W-1:0] PER_DEFAULT = 31'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_RESET = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

    typedef enum logic {
        KIND_ACK    = 1'b0,
        KIND_EXPIRY = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_SELECT,
        S_FIRE
    } state_t;

    typedef struct packed {
        logic clear;    // start of a tick: drop all due entries
        logic capture;  // enter one scanned timer
        logic advance;  // one expiry has been issued
    } pick_ctl_t;

endpackage

// ----- src/mteu_ram.sv -----
// Timer entry memory: one write port, one read port, registered read data.
// Holds {period, wakeup time} per timer. No package dependencies.
`timescale 1ns / 1ps

module mteu_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 63
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/mteu_pick.sv -----
// Expiry ordering for one tick: ranks due timers by age as they are scanned,
// then hands them out oldest first. Depends on mteu_pkg and the assertion header.
`timescale 1ns / 1ps
`include "multi_timer_expiry_unit_assert.svh"

module mteu_pick
    import mteu_pkg::*;
#(
    parameter int ST    = 8,
    parameter int IW    = 3,
    parameter int AGE_W = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pick_ctl_t        ctl,
    input  logic [IW-1:0]    cap_idx,
    input  logic [AGE_W-1:0] cap_age,
    input  logic             cap_due,
    output logic [IW-1:0]    best,
    output logic             done,
    output logic             last
);

    localparam int CW = $clog2(ST + 1);

    logic [ST-1:0]    due_reg;
    logic [AGE_W-1:0] age_reg  [ST];
    logic [IW-1:0]    rank_reg [ST];
    logic [CW-1:0]    due_cnt_reg;
    logic [CW-1:0]    fire_cnt_reg;

    logic [ST-1:0]    beats;
    logic [ST-1:0]    hit_vec;
    logic [IW-1:0]    cap_rank;

    // Entries are scanned in index order, so an earlier one wins a tie.
    always_comb
    begin
        for (int k = 0; k < ST; k++)
        begin
            beats[k] = due_reg[k] && (age_reg[k] >= cap_age);
        end
        cap_rank = IW'($countones(beats));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg      <= '0;
            due_cnt_reg  <= '0;
            fire_cnt_reg <= '0;
        end
        else if (ctl.clear)
        begin
            due_reg      <= '0;
            due_cnt_reg  <= '0;
            fire_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.capture && cap_due)
            begin
                due_reg[cap_idx] <= 1'b1;
                due_cnt_reg      <= CW'(due_cnt_reg + 1'b1);
            end
            if (ctl.advance)
            begin
                fire_cnt_reg <= CW'(fire_cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture && cap_due)
        begin
            for (int k = 0; k < ST; k++)
            begin
                if (IW'(k) == cap_idx)
                begin
                    age_reg[k]  <= cap_age;
                    rank_reg[k] <= cap_rank;
                end
                else if (due_reg[k] && !beats[k])
                begin
                    // new entry is older: push this one back
                    rank_reg[k] <= IW'(rank_reg[k] + 1'b1);
                end
            end
        end
    end

    always_comb
    begin
        best = '0;
        for (int k = 0; k < ST; k++)
        begin
            hit_vec[k] = due_reg[k] && (CW'(rank_reg[k]) == fire_cnt_reg);
            if (hit_vec[k])
            begin
                best = IW'(k);
            end
        end
    end

    assign done = (fire_cnt_reg == due_cnt_reg);
    assign last = (CW'(fire_cnt_reg + 1'b1) == due_cnt_reg);

    `MTEU_ASSERT_IMP(a_fire_le_due, 1'b1, fire_cnt_reg <= due_cnt_reg, "more expiries than due timers")
    `MTEU_ASSERT_IMP(a_rank_unique, 1'b1, $onehot0(hit_vec), "two due timers share a rank")

endmodule

// ----- src/multi_timer_expiry_unit.sv -----
// Channel   Handshake              Payload
// cmd       cmd_valid/cmd_ready    opcode, timer_index, period_ticks
// res       res_valid/res_ready    kind, which_timer, ok, running, last
// cfg       cfg_wr_en              cfg_wr_data (autoreload mask)
//
// Start, stop, reset and query do one memory read, then one update.
// A tick scans S = min(NUM_TIMERS, 8) entries through the single memory read
// port, then issues E expiries, each a read plus a write-back if it reloads.
// One item is in flight at a time; cmd_ready is high in idle.
// A stalled res channel holds the machine before each result is loaded.
// Reset is immediate: no memory clearing pass; unwritten periods read as one.
// Depends on mteu_pkg, mteu_ram, mteu_pick and the assertion header.
`timescale 1ns / 1ps
`include "multi_timer_expiry_unit_assert.svh"

module multi_timer_expiry_unit
    import mteu_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  timer_index,
    input  logic [PER_W-1:0]  period_ticks,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              kind,
    output logic [IDX_W-1:0]  which_timer,
    output logic              ok,
    output logic              running,
    output logic              last,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data
);

    // only the low eight timers can ever be started
    localparam int ST    = (NUM_TIMERS < IDX_SPAN) ? NUM_TIMERS : IDX_SPAN;
    localparam int IW    = (ST > 1) ? $clog2(ST) : 1;
    localparam int TW    = TIME_WIDTH;
    localparam int AGE_W = TIME_WIDTH - 1;
    localparam int DW    = PER_W + TIME_WIDTH;
    localparam int SW    = (TIME_WIDTH > PER_W) ? TIME_WIDTH : PER_W;

    state_t state_reg, state_next;

    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PER_W-1:0]  per_reg;
    logic [IW-1:0]     scan_ptr_reg;
    logic [IW-1:0]     best_reg;
    logic              last_sel_reg;
    logic [TW-1:0]     count_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [ST-1:0]     running_reg;
    logic [ST-1:0]     written_reg;

    logic              res_valid_reg;
    logic              kind_reg;
    logic [IDX_W-1:0]  which_reg;
    logic              ok_reg;
    logic              run_out_reg;
    logic              last_reg;

    // control strobes
    logic      accept;
    logic      slot_free;
    logic      rd_en;
    logic [IW-1:0] rd_addr;
    logic      wr_en;
    logic      op_load;
    logic      fire_load;
    pick_ctl_t pick_ctl;

    // datapath
    logic [DW-1:0]    rd_data;
    logic [PER_W-1:0] rd_per;
    logic [TW-1:0]    rd_wake;
    logic [IW-1:0]    cur_idx;
    logic [PER_W-1:0] eff_per;
    logic [PER_W-1:0] launch_per;
    logic [SW-1:0]    wake_sum;
    logic [TW-1:0]    age;
    logic             idx_ok;
    logic             cur_run;
    logic             op_ok;
    logic             op_run;
    logic             op_wr;
    logic             reload;
    logic [IW-1:0]    pick_best;
    logic             pick_done;
    logic             pick_last;

    assign accept    = cmd_valid && cmd_ready;
    assign slot_free = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------- datapath
    assign rd_per  = rd_data[DW-1:TW];
    assign rd_wake = rd_data[TW-1:0];
    assign cur_idx = (state_reg == S_FIRE) ? best_reg : idx_reg[IW-1:0];
    assign eff_per = written_reg[cur_idx] ? rd_per : PER_DEFAULT;
    assign launch_per = (state_reg == S_OP && op_reg == OP_START) ? per_reg : eff_per;
    assign wake_sum   = SW'(count_reg) + SW'(launch_per);
    assign age        = count_reg - rd_wake;
    assign idx_ok     = (32'(idx_reg) < NUM_TIMERS);
    assign cur_run    = running_reg[cur_idx];
    assign reload     = mask_reg[IDX_W'(best_reg)];

    always_comb
    begin
        op_ok  = 1'b1;
        op_run = cur_run;
        op_wr  = 1'b0;
        unique case (op_reg)
            OP_START:
            begin
                op_run = 1'b1;
                op_wr  = 1'b1;
            end
            OP_STOP:
            begin
                op_run = 1'b0;
            end
            OP_RESET:
            begin
                if (eff_per == '0)
                begin
                    op_ok = 1'b0;
                end
                else
                begin
                    op_run = 1'b1;
                    op_wr  = 1'b1;
                end
            end
            OP_QUERY:
            begin
                op_run = cur_run;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
        if (!idx_ok)
        begin
            op_ok  = 1'b0;
            op_run = 1'b0;
            op_wr  = 1'b0;
        end
    end

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (opcode == OP_TICK) ? S_SCAN : S_OP;
                end
            end
            S_OP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_ptr_reg == IW'(ST - 1))
                begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                state_next = pick_done ? S_IDLE : S_FIRE;
            end
            S_FIRE:
            begin
                if (slot_free)
                begin
                    state_next = S_SELECT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        op_load  = 1'b0;
        fire_load = 1'b0;
        pick_ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = (opcode == OP_TICK) ? '0 : timer_index[IW-1:0];
                    pick_ctl.clear = (opcode == OP_TICK);
                end
            end
            S_OP:
            begin
                op_load = slot_free;
                wr_en   = slot_free && op_wr;
            end
            S_SCAN:
            begin
                pick_ctl.capture = 1'b1;
                if (scan_ptr_reg != IW'(ST - 1))
                begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(scan_ptr_reg + 1'b1);
                end
            end
            S_SELECT:
            begin
                if (!pick_done)
                begin
                    rd_en            = 1'b1;
                    rd_addr          = pick_best;
                    pick_ctl.advance = 1'b1;
                end
            end
            S_FIRE:
            begin
                fire_load = slot_free;
                wr_en     = slot_free && reload;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mask_reg      <= '0;
            running_reg   <= '0;
            written_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (accept && opcode == OP_TICK)
            begin
                count_reg <= TW'(count_reg + 1'b1);
            end
            if (op_load && idx_ok)
            begin
                running_reg[cur_idx] <= op_run;
                if (op_wr)
                begin
                    written_reg[cur_idx] <= 1'b1;
                end
            end
            if (fire_load)
            begin
                running_reg[best_reg] <= reload;
            end
            if (op_load || fire_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= opcode;
            idx_reg      <= timer_index;
            per_reg      <= period_ticks;
            scan_ptr_reg <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            scan_ptr_reg <= IW'(scan_ptr_reg + 1'b1);
        end
        if (pick_ctl.advance)
        begin
            best_reg     <= pick_best;
            last_sel_reg <= pick_last;
        end
        if (op_load)
        begin
            kind_reg    <= KIND_ACK;
            which_reg   <= idx_reg;
            ok_reg      <= op_ok;
            run_out_reg <= op_run;
            last_reg    <= 1'b1;
        end
        else if (fire_load)
        begin
            kind_reg    <= KIND_EXPIRY;
            which_reg   <= IDX_W'(best_reg);
            ok_reg      <= 1'b1;
            run_out_reg <= reload;
            last_reg    <= last_sel_reg;
        end
    end

    // ---------------------------------------------------------------- units
    // Reads and writes never touch the same entry in one cycle: the sequencer
    // reads an entry and writes it back only in the following state.
    mteu_ram #(
        .DEPTH (ST),
        .AW    (IW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_idx),
        .wr_data ({launch_per, wake_sum[TW-1:0]}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mteu_pick #(
        .ST    (ST),
        .IW    (IW),
        .AGE_W (AGE_W)
    ) u_pick (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (pick_ctl),
        .cap_idx (scan_ptr_reg),
        .cap_age (age[AGE_W-1:0]),
        .cap_due (running_reg[scan_ptr_reg] && !age[TW-1]),
        .best    (pick_best),
        .done    (pick_done),
        .last    (pick_last)
    );

    assign res_valid   = res_valid_reg;
    assign kind        = kind_reg;
    assign which_timer = which_reg;
    assign ok          = ok_reg;
    assign running     = run_out_reg;
    assign last        = last_reg;

    `MTEU_ASSERT_NXT(a_tick_count, accept && opcode == OP_TICK, count_reg == TW'($past(count_reg) + 1'b1), "tick did not advance count")
    `MTEU_ASSERT_IMP(a_fire_started, state_reg == S_FIRE, written_reg[best_reg] && running_reg[best_reg], "expiring timer was never started")
    `MTEU_ASSERT_NXT(a_fire_flag, fire_load, running_reg[best_reg] == run_out_reg, "expiry running flag mismatch")

endmodule

// ----- sim/mteu_checker.sv -----
// Checker for the multi-timer expiry unit: watches the command, result and config ports,
// predicts every result and compares it field by field. Depends on mteu_pkg.
`timescale 1ns / 1ps

module mteu_checker
    import mteu_pkg::*;
#(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  timer_index,
    input  logic [PER_W-1:0]  period_ticks,
    input  logic              res_valid,
    input  logic              res_ready,
    input  logic              kind,
    input  logic [IDX_W-1:0]  which_timer,
    input  logic              ok,
    input  logic              running,
    input  logic              last,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    output int                mismatch_count,
    output int                results_owed
);

    localparam int MAX_FIRE  = 8;
    localparam int MAX_PRINT = 40;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  which_timer;
        logic              ok;
        logic              running;
        logic              last;
    } timer_result_t;

    logic [TIME_WIDTH-1:0] tick_now;
    logic [TIME_WIDTH-1:0] wake_at [NUM_TIMERS];
    logic [PER_W-1:0]      reload_period [NUM_TIMERS];
    logic                  armed [NUM_TIMERS];
    logic [MASK_W-1:0]     reload_mask;
    timer_result_t         owed_q [$];

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINT)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic arm_timer(input int t, input logic [PER_W-1:0] p);
        reload_period[t] = p;
        wake_at[t]       = tick_now + TIME_WIDTH'(p);
        armed[t]         = 1'b1;
    endtask

    task automatic fire_due_timers();
        logic [TIME_WIDTH-1:0] age [NUM_TIMERS];
        logic                  due [NUM_TIMERS];
        int                    order [MAX_FIRE];
        int                    fired;
        int                    best;
        int                    t;
        timer_result_t         ev;
        tick_now = tick_now + 1'b1;
        // a wakeup is reached when count - wakeup lies in the lower half of the ring
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            age[i] = tick_now - wake_at[i];
            due[i] = armed[i] && !age[i][TIME_WIDTH-1];
        end
        fired = 0;
        while (fired < MAX_FIRE)
        begin
            best = -1;
            // oldest first; strict compare leaves ties to the lower index
            for (int i = 0; i < NUM_TIMERS; i++)
                if (due[i] && (best < 0 || age[i] > age[best]))
                    best = i;
            if (best < 0)
                break;
            due[best]    = 1'b0;
            order[fired] = best;
            fired++;
        end
        for (int k = 0; k < fired; k++)
        begin
            t          = order[k];
            armed[t]   = 1'b0;
            wake_at[t] = '0;
            if (t < MASK_W && reload_mask[t])
                arm_timer(t, reload_period[t]);
            ev.kind        = KIND_EXPIRY;
            ev.which_timer = IDX_W'(t);
            ev.ok          = 1'b1;
            ev.running     = armed[t];
            ev.last        = (k == fired - 1);
            owed_q.push_back(ev);
        end
    endtask

    task automatic predict_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                   input logic [PER_W-1:0] per);
        timer_result_t ack;
        ack.kind        = KIND_ACK;
        ack.which_timer = idx;
        ack.ok          = 1'b1;
        ack.running     = 1'b0;
        ack.last        = 1'b1;
        if (op == OP_TICK)
        begin
            fire_due_timers();
            return;
        end
        if (int'(idx) >= NUM_TIMERS)
        begin
            ack.ok = 1'b0;
            owed_q.push_back(ack);
            return;
        end
        case (op)
            OP_START: arm_timer(idx, per);
            OP_STOP:
            begin
                armed[idx]   = 1'b0;
                wake_at[idx] = '0;
            end
            OP_RESET:
            begin
                if (reload_period[idx] == '0)
                    ack.ok = 1'b0;
                else
                    arm_timer(idx, reload_period[idx]);
            end
            OP_QUERY: ;
            default: ack.ok = 1'b0;
        endcase
        ack.running = armed[idx];
        owed_q.push_back(ack);
    endtask

    task automatic check_result();
        timer_result_t want;
        if (owed_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result: kind %0d timer %0d", kind, which_timer));
            return;
        end
        want = owed_q.pop_front();
        if (kind != want.kind)
            report_mismatch($sformatf("kind got %0d expected %0d", kind, want.kind));
        if (which_timer != want.which_timer)
            report_mismatch($sformatf("which_timer got %0d expected %0d",
                                      which_timer, want.which_timer));
        if (ok != want.ok)
            report_mismatch($sformatf("ok got %0d expected %0d (timer %0d)",
                                      ok, want.ok, want.which_timer));
        if (running != want.running)
            report_mismatch($sformatf("running got %0d expected %0d (timer %0d)",
                                      running, want.running, want.which_timer));
        if (last != want.last)
            report_mismatch($sformatf("last got %0d expected %0d (timer %0d)",
                                      last, want.last, want.which_timer));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now    = '0;
            reload_mask = '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                wake_at[i]       = '0;
                reload_period[i] = PER_DEFAULT;
                armed[i]         = 1'b0;
            end
            owed_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                reload_mask = cfg_wr_data;
            if (cmd_valid && cmd_ready)
                predict_command(opcode, timer_index, period_ticks);
            if (res_valid && res_ready)
                check_result();
        end
        results_owed = owed_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the timer unit testbench: clock, reset, command and config stimulus, result
// back-pressure and the verdict. Depends on mteu_pkg, mteu_checker and the unit itself.
`timescale 1ns / 1ps

module tb_top;
    import mteu_pkg::*;

    localparam int NUM_TIMERS     = 8;
    localparam int TIME_WIDTH     = 32;
    localparam int RAND_PHASES    = 5;
    localparam int PHASE_ITEMS    = 41;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_NS     = 8_000_000;

    localparam logic [OP_W-1:0] OP_CODE_MAX = '1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  timer_index;
    logic [PER_W-1:0]  period_ticks;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic              kind;
    logic [IDX_W-1:0]  which_timer;
    logic              ok;
    logic              running;
    logic              last;
    logic              cfg_wr_en;
    logic [MASK_W-1:0] cfg_wr_data;

    int   mismatch_count;
    int   results_owed;
    int   burst_left = 0;
    logic hold_toggle = 1'b0;

    always #5 clk = ~clk;

    multi_timer_expiry_unit #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .opcode       (opcode),
        .timer_index  (timer_index),
        .period_ticks (period_ticks),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kind         (kind),
        .which_timer  (which_timer),
        .ok           (ok),
        .running      (running),
        .last         (last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    mteu_checker #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) timer_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .opcode         (opcode),
        .timer_index    (timer_index),
        .period_ticks   (period_ticks),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .kind           (kind),
        .which_timer    (which_timer),
        .ok             (ok),
        .running        (running),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(25, 70);
    endfunction

    function automatic int sender_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(8, 20);
            return 0;
        end
        return pick_gap();
    endfunction

    function automatic logic [PER_W-1:0] start_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return PER_W'($urandom_range(0, 8));
        if (r < 90)
            return PER_W'($urandom_range(9, 40));
        if (r < 94)
            return '1;
        return PER_W'($urandom());
    endfunction

    // hold the transfer until the unit takes it; keep valid up across back-to-back items
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [PER_W-1:0] per);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        opcode       <= op;
        timer_index  <= idx;
        period_ticks <= per;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic send_random_cmd();
        int                r;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [PER_W-1:0]  per;
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, NUM_TIMERS - 1));
        per = PER_W'($urandom());
        if (r < 45)
            op = OP_TICK;
        else if (r < 65)
        begin
            op  = OP_START;
            per = start_period();
        end
        else if (r < 75)
            op = OP_STOP;
        else if (r < 85)
            op = OP_RESET;
        else if (r < 95)
            op = OP_QUERY;
        else
            op = OP_W'($urandom_range(int'(OP_QUERY) + 1, int'(OP_CODE_MAX)));
        send_cmd(op, idx, per);
    endtask

    // drop valid, wait out every owed result, then let a silent tick finish
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_directed();
        send_cmd(OP_QUERY, 3'd0, '0);
        send_cmd(OP_RESET, 3'd7, '0);       // default period of one
        send_cmd(OP_TICK,  3'd0, '0);
        send_cmd(OP_START, 3'd0, '0);       // zero period fires on the next tick
        send_cmd(OP_START, 3'd1, '1);
        send_cmd(OP_START, 3'd2, 31'd3);
        send_cmd(OP_TICK,  3'd5, '1);
        send_cmd(OP_QUERY, 3'd1, '0);
        send_cmd(OP_STOP,  3'd1, '0);
        send_cmd(OP_QUERY, 3'd1, '0);
        send_cmd(OP_RESET, 3'd0, '0);       // refused: stored period is zero
        send_cmd(OP_W'(int'(OP_QUERY) + 1), 3'd2, '0);
        send_cmd(OP_CODE_MAX, 3'd3, '1);
        send_cmd(OP_START, 3'd6, 31'd2);
        send_cmd(OP_START, 3'd3, 31'd1);
        send_cmd(OP_START, 3'd4, 31'd1);
        send_cmd(OP_TICK,  3'd0, '0);       // equal wakeups: lower index first
        send_cmd(OP_TICK,  3'd0, '0);
        wait_idle();
        write_mask('1);
        send_cmd(OP_START, 3'd5, '0);
        send_cmd(OP_START, 3'd7, 31'd2);
        send_cmd(OP_TICK,  3'd0, '0);       // zero period reloads and stays running
        send_cmd(OP_TICK,  3'd0, '0);
        send_cmd(OP_TICK,  3'd0, '0);
        send_cmd(OP_STOP,  3'd5, '0);
        send_cmd(OP_W'(int'(OP_CODE_MAX) - 1), 3'd5, '1);
    endtask

    initial
    begin
        int waited;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        opcode       = OP_TICK;
        timer_index  = '0;
        period_ticks = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_idle();
            if (phase == 0)
                write_mask('0);
            else if (phase == 2)
                write_mask('1);
            else if (phase == 4)
                write_mask(8'hA5);
            else
                write_mask(MASK_W'($urandom()));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // starve the result side while commands keep coming
                if (phase == 1 && n == 12)
                    hold_toggle <= ~hold_toggle;
                send_random_cmd();
            end
        end

        cmd_valid <= 1'b0;
        waited = 0;
        @(negedge clk);
        while (results_owed != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (results_owed != 0)
            $display("ERROR: %0d expected results never arrived", results_owed);
        if (mismatch_count == 0 && results_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result side: ready runs, random stalls, and one long hold on request
    initial
    begin
        logic hold_seen;
        hold_seen = 1'b0;
        forever
        begin
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                int run_len;
                int stall_len;
                run_len   = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 100)
                                                         : $urandom_range(1, 16);
                res_ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                stall_len = pick_gap();
                if (stall_len > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (stall_len) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
